@@ rtl/ffa_pkg.sv @@
// Package for the first-fit heap allocator.
// Holds the payload structs, the table entry type and the status codes.
// No dependencies.
package ffa_pkg;

  localparam int unsigned FieldW = 23;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_FREED     = 3'd2,
    ST_REFUSED   = 3'd3,
    ST_NO_BLOCK  = 3'd4,
    ST_NULL      = 3'd5
  } status_e;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [FieldW-1:0] request_size;
    logic [FieldW-1:0] payload_offset;
    logic              free_permitted;
  } req_t;

  typedef struct packed {
    logic [FieldW-1:0] result_offset;
    logic [2:0]        status;
  } rsp_t;

  // One row of the block table.
  typedef struct packed {
    logic              used;
    logic [FieldW-1:0] size;
  } entry_t;

endpackage

@@ rtl/ffa_mem.sv @@
// Block table memory: one write port, one registered read port.
// Entry 0 reads as its reset value until first written. Depends on ffa_pkg.
module ffa_mem import ffa_pkg::*; #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  entry_t          entry0_rst_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  entry_t          wdata_i
);

  entry_t mem [Depth];
  entry_t rdata_q;
  logic   init_q;
  logic   zero_q;

  // Array write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // Valid mark for entry 0, and whether the last read hit the unwritten entry 0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      if (we_i && (waddr_i == '0)) begin
        init_q <= 1'b1;
      end
      if (re_i) begin
        zero_q <= (raddr_i == '0) && !init_q;
      end
    end
  end

  assign rdata_o = zero_q ? entry0_rst_i : rdata_q;

endmodule

@@ rtl/ffa_ctrl.sv @@
// Sequencer for the allocator: table walks, split shift and merge compaction.
// Drives the table memory ports. Depends on ffa_pkg.
module ffa_ctrl import ffa_pkg::*; #(
  parameter int unsigned MaxBlocks   = 64,
  parameter int unsigned HeaderBytes = 12,
  parameter int unsigned IdxW        = 6,
  parameter int unsigned CntW        = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  req_t            req_i,
  output logic            busy_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output rsp_t            res_o,
  output logic            re_o,
  output logic [IdxW-1:0] raddr_o,
  input  entry_t          rdata_i,
  output logic            we_o,
  output logic [IdxW-1:0] waddr_o,
  output entry_t          wdata_o
);

  localparam int unsigned HdrW = FieldW + IdxW + 1;
  localparam logic [FieldW-1:0] HdrSz = FieldW'(HeaderBytes);

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_CHK, S_SH_RD, S_SH_WR, S_SP_HI, S_SP_LO,
    S_F_RD, S_F_CHK, S_M_RD, S_M_PROC, S_M_END, S_DONE
  } state_e;

  state_e            state_q;
  req_t              req_q;
  rsp_t              res_q;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   i_q;
  logic [CntW-1:0]   j_q;
  logic [CntW-1:0]   w_q;
  logic [HdrW-1:0]   hdr_q;
  logic [FieldW-1:0] rest_q;
  entry_t            pend_q;
  logic              pend_ok_q;

  logic              fits;
  logic [FieldW-1:0] rest;
  logic [HdrW-1:0]   hdr_next;
  logic [HdrW-1:0]   pay_off;

  assign fits     = !rdata_i.used && (rdata_i.size >= req_q.request_size);
  assign rest     = rdata_i.size - req_q.request_size;
  assign hdr_next = hdr_q + HdrW'(HeaderBytes) + HdrW'(rdata_i.size);
  assign pay_off  = hdr_q + HdrW'(HeaderBytes);

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  // Memory port control.
  always_comb begin
    re_o    = 1'b0;
    raddr_o = i_q[IdxW-1:0];
    we_o    = 1'b0;
    waddr_o = i_q[IdxW-1:0];
    wdata_o = rdata_i;
    unique case (state_q)
      S_A_RD: re_o = (i_q != count_q);
      S_F_RD: re_o = (i_q != count_q);
      S_M_RD: re_o = (i_q != count_q);
      S_A_CHK: begin
        if (fits && !(rest > HdrSz && count_q < CntW'(MaxBlocks))) begin
          we_o         = 1'b1;
          wdata_o.used = 1'b1;
        end
      end
      S_SH_RD: begin
        re_o    = (j_q != i_q + CntW'(1));
        raddr_o = j_q[IdxW-1:0] - IdxW'(1);
      end
      S_SH_WR: begin
        we_o    = 1'b1;
        waddr_o = j_q[IdxW-1:0];
      end
      S_SP_HI: begin
        we_o    = 1'b1;
        waddr_o = i_q[IdxW-1:0] + IdxW'(1);
        wdata_o = '{used: 1'b0, size: rest_q - HdrSz};
      end
      S_SP_LO: begin
        we_o    = 1'b1;
        wdata_o = '{used: 1'b1, size: req_q.request_size};
      end
      S_F_CHK: begin
        if (pay_off == HdrW'(req_q.payload_offset)) begin
          we_o         = 1'b1;
          wdata_o.used = 1'b0;
        end
      end
      S_M_PROC: begin
        if (pend_ok_q && !(!pend_q.used && !rdata_i.used)) begin
          we_o    = 1'b1;
          waddr_o = w_q[IdxW-1:0];
          wdata_o = pend_q;
        end
      end
      S_M_END: begin
        we_o    = 1'b1;
        waddr_o = w_q[IdxW-1:0];
        wdata_o = pend_q;
      end
      default: ;
    endcase
  end

  // State and registered results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= CntW'(1);
      pend_ok_q <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      w_q       <= '0;
      hdr_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            req_q <= req_i;
            i_q   <= '0;
            hdr_q <= '0;
            res_q.result_offset <= '0;
            if (req_i.req_type == REQ_ALLOC) begin
              state_q <= S_A_RD;
            end else if (req_i.payload_offset == '0) begin
              res_q.status <= ST_NULL;
              state_q      <= S_DONE;
            end else if (!req_i.free_permitted) begin
              res_q.status <= ST_REFUSED;
              state_q      <= S_DONE;
            end else begin
              state_q <= S_F_RD;
            end
          end
        end
        S_A_RD: begin
          if (i_q == count_q) begin
            res_q.status <= ST_NO_FIT;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_A_CHK;
          end
        end
        S_A_CHK: begin
          if (fits) begin
            res_q.result_offset <= pay_off[FieldW-1:0];
            res_q.status        <= ST_ALLOCATED;
            rest_q              <= rest;
            j_q                 <= count_q;
            if (rest > HdrSz && count_q < CntW'(MaxBlocks)) begin
              state_q <= S_SH_RD;
            end else begin
              state_q <= S_DONE;
            end
          end else begin
            hdr_q   <= hdr_next;
            i_q     <= i_q + CntW'(1);
            state_q <= S_A_RD;
          end
        end
        // Shift the rows above the split point up by one, top first.
        S_SH_RD: begin
          state_q <= (j_q == i_q + CntW'(1)) ? S_SP_HI : S_SH_WR;
        end
        S_SH_WR: begin
          j_q     <= j_q - CntW'(1);
          state_q <= S_SH_RD;
        end
        S_SP_HI: state_q <= S_SP_LO;
        S_SP_LO: begin
          count_q <= count_q + CntW'(1);
          state_q <= S_DONE;
        end
        S_F_RD: begin
          if (i_q == count_q) begin
            res_q.status <= ST_NO_BLOCK;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_F_CHK;
          end
        end
        S_F_CHK: begin
          if (pay_off == HdrW'(req_q.payload_offset)) begin
            res_q.status <= ST_FREED;
            i_q          <= '0;
            w_q          <= '0;
            pend_ok_q    <= 1'b0;
            state_q      <= S_M_RD;
          end else begin
            hdr_q   <= hdr_next;
            i_q     <= i_q + CntW'(1);
            state_q <= S_F_RD;
          end
        end
        // Merge pass: compact the table, folding runs of free rows together.
        S_M_RD: begin
          state_q <= (i_q == count_q) ? S_M_END : S_M_PROC;
        end
        S_M_PROC: begin
          pend_ok_q <= 1'b1;
          if (!pend_ok_q) begin
            pend_q <= rdata_i;
          end else if (!pend_q.used && !rdata_i.used) begin
            pend_q.size <= pend_q.size + HdrSz + rdata_i.size;
          end else begin
            pend_q <= rdata_i;
            w_q    <= w_q + CntW'(1);
          end
          i_q     <= i_q + CntW'(1);
          state_q <= S_M_RD;
        end
        S_M_END: begin
          count_q <= w_q + CntW'(1);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The table never empties or overflows.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CntW'(MaxBlocks)))
    else $error("block count out of range");

  // Compaction never writes past the row being read.
  a_merge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_M_PROC) |-> (w_q < i_q + CntW'(1)))
    else $error("merge write overtook read");

  // Checked rows always lie inside the table.
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_CHK || state_q == S_F_CHK) |-> (i_q < count_q))
    else $error("walk past table end");

  // A split always grows the table by one row.
  a_split_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SP_LO) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("split did not add a row");

endmodule

@@ rtl/first_fit_heap_allocator_unit.sv @@
// First-fit heap allocator top level: table memory, sequencer, output register.
// Allocate walks rows to the first fit and on a split shifts the rows above it up;
// free walks rows to the block and then makes a merge pass over the table.
// One request is in work at a time; the table memory's single read port sets the pace.
// After reset the table holds one free block of the whole heap less one header.
// Depends on ffa_pkg, ffa_mem and ffa_ctrl.
module first_fit_heap_allocator_unit import ffa_pkg::*; #(
  parameter int unsigned MaxBlocks   = 64,
  parameter int unsigned HeapBytes   = 4194304,
  parameter int unsigned HeaderBytes = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned IdxW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int unsigned CntW = $clog2(MaxBlocks + 1);

  logic            busy;
  logic            res_valid;
  logic            res_ready;
  rsp_t            res;
  logic            re;
  logic [IdxW-1:0] raddr;
  entry_t          rdata;
  logic            we;
  logic [IdxW-1:0] waddr;
  entry_t          wdata;
  entry_t          entry0_rst;
  logic            out_valid_q;
  rsp_t            out_rsp_q;

  assign entry0_rst = '{used: 1'b0, size: FieldW'(HeapBytes - HeaderBytes)};

  ffa_mem #(.Depth(MaxBlocks), .IdxW(IdxW)) u_mem (
    .clk_i, .rst_ni,
    .entry0_rst_i(entry0_rst),
    .re_i(re), .raddr_i(raddr), .rdata_o(rdata),
    .we_i(we), .waddr_i(waddr), .wdata_i(wdata)
  );

  ffa_ctrl #(
    .MaxBlocks(MaxBlocks), .HeaderBytes(HeaderBytes), .IdxW(IdxW), .CntW(CntW)
  ) u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i(in_valid_i), .req_i(in_req_i), .busy_o(busy),
    .res_valid_o(res_valid), .res_ready_i(res_ready), .res_o(res),
    .re_o(re), .raddr_o(raddr), .rdata_i(rdata),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata)
  );

  assign in_stall_o = busy;
  assign res_ready  = !out_valid_q || !out_stall_i;

  // Output register: holds a result until its transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_rsp_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
